>>> rtl/core/mh2_pkg.sv
// ----------------------------------------------------------------------------
// mh2_pkg
// Shared constants, sequencer states and control types for the MurmurHash2
// engine.
// ----------------------------------------------------------------------------
package mh2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  localparam logic [1:0] TAIL_ONE   = 2'd1;
  localparam logic [1:0] TAIL_TWO   = 2'd2;
  localparam logic [1:0] TAIL_THREE = 2'd3;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_K1   = 9'b000000010,
    S_K2   = 9'b000000100,
    S_H    = 9'b000001000,
    S_HX   = 9'b000010000,
    S_T    = 9'b000100000,
    S_TX   = 9'b001000000,
    S_F    = 9'b010000000,
    S_FX   = 9'b100000000
  } seq_state_t;

  // request to the shared multiplier
  typedef struct packed {
    logic        en;
    logic [31:0] operand;
  } mul_req_t;

  // finished hash handed to the output stage
  typedef struct packed {
    logic        valid;
    logic [31:0] hash;
  } fin_t;

endpackage

>>> rtl/core/mh2_if.sv
// ----------------------------------------------------------------------------
// mh2 channel interfaces
// Valid/ready channels for message words and hash results.
// ----------------------------------------------------------------------------
interface mh2_in_if;
  logic        valid;
  logic        ready;
  logic        first;
  logic [31:0] msg_length;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;

  modport source (output valid, first, msg_length, data_word, byte_count, last,
                  input ready);
  modport sink   (input valid, first, msg_length, data_word, byte_count, last,
                  output ready);
endinterface

interface mh2_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash;

  modport source (output valid, hash, input ready);
  modport sink   (input valid, hash, output ready);
endinterface

>>> rtl/core/mh2_mul.sv
// ----------------------------------------------------------------------------
// mh2_mul
// Shared multiplier: registered low 32 bits of operand times the mix constant.
// ----------------------------------------------------------------------------
module mh2_mul
  import mh2_pkg::*;
(
  input  logic        clk,
  input  mul_req_t    req,
  output logic [31:0] product
);

  logic [31:0] prod_r;
  logic [31:0] prod_nxt;

  // only the low word is kept, so a 32-bit wide product suffices
  assign prod_nxt = req.operand * MIX_MUL;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= prod_nxt;
    end
  end

  assign product = prod_r;

endmodule

>>> rtl/core/mh2_seq.sv
// ----------------------------------------------------------------------------
// mh2_seq
// Sequencer and hash state: steps each word through the shared multiplier
// and runs the final avalanche on the last word.
// ----------------------------------------------------------------------------
module mh2_seq
  import mh2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mh2_in_if.sink      in_chan,
  output mul_req_t    mul_req,
  input  logic [31:0] product,
  output fin_t        fin,
  input  logic        fin_ready
);

  seq_state_t  state_r, state_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] w_r, w_nxt;
  logic [31:0] k_r, k_nxt;
  logic        last_r, last_nxt;

  logic        accept;
  logic        is_full;
  logic        is_tail;
  logic [31:0] masked;
  logic [31:0] h_seed;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  // counts above four behave as a full word
  assign is_full = in_chan.byte_count[2];
  assign is_tail = !is_full && (in_chan.byte_count[1:0] != 2'd0);
  assign h_seed  = in_chan.first ? in_chan.msg_length : h_r;

  always_comb begin
    if (is_full) begin
      masked = in_chan.data_word;
    end else begin
      case (in_chan.byte_count[1:0])
        TAIL_ONE:   masked = {24'd0, in_chan.data_word[7:0]};
        TAIL_TWO:   masked = {16'd0, in_chan.data_word[15:0]};
        TAIL_THREE: masked = {8'd0, in_chan.data_word[23:0]};
        default:    masked = in_chan.data_word;
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    h_nxt           = h_r;
    w_nxt           = w_r;
    k_nxt           = k_r;
    last_nxt        = last_r;
    mul_req.en      = 1'b0;
    mul_req.operand = w_r;
    fin.valid       = 1'b0;
    fin.hash        = product ^ (product >> FIN_SHIFT_B);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          h_nxt    = h_seed;
          w_nxt    = masked;
          last_nxt = in_chan.last;
          if (is_full) begin
            state_nxt = S_K1;
          end else if (is_tail) begin
            state_nxt = S_T;
          end else if (in_chan.last) begin
            state_nxt = S_F;
          end
        end
      end
      S_K1: begin
        mul_req.en      = 1'b1;
        mul_req.operand = w_r;
        state_nxt       = S_K2;
      end
      S_K2: begin
        mul_req.en      = 1'b1;
        mul_req.operand = product ^ (product >> MIX_SHIFT);
        state_nxt       = S_H;
      end
      S_H: begin
        k_nxt           = product;
        mul_req.en      = 1'b1;
        mul_req.operand = h_r;
        state_nxt       = S_HX;
      end
      S_HX: begin
        h_nxt     = product ^ k_r;
        state_nxt = last_r ? S_F : S_IDLE;
      end
      S_T: begin
        mul_req.en      = 1'b1;
        mul_req.operand = h_r ^ w_r;
        state_nxt       = S_TX;
      end
      S_TX: begin
        h_nxt     = product;
        state_nxt = last_r ? S_F : S_IDLE;
      end
      S_F: begin
        mul_req.en      = 1'b1;
        mul_req.operand = h_r ^ (h_r >> FIN_SHIFT_A);
        state_nxt       = S_FX;
      end
      S_FX: begin
        // product holds until the output stage takes the word
        fin.valid = 1'b1;
        if (fin_ready) begin
          h_nxt     = 32'd0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      h_r     <= 32'd0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      h_r     <= h_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    k_r <= k_nxt;
  end

endmodule

>>> rtl/core/murmur2_hash_engine.sv
// ----------------------------------------------------------------------------
// murmur2_hash_engine
// 32-bit MurmurHash2, seed zero, over a message of little-endian words.
// ----------------------------------------------------------------------------
// A message is a run of words on in_chan; the first word carries the total
// byte length that seeds the hash, the last word may hold 0 to 3 tail bytes
// and closes the message with one hash word on out_chan. All arithmetic goes
// through one registered 32x32 multiplier by the mix constant, so in_chan.ready
// is low while a word is worked: after it is accepted, a full word takes three
// products in turn, a partial word one and an empty word none. A last word adds
// the avalanche product, and the result sits in the output register the cycle
// after the output stage takes it; a stalled result holds the engine until the
// prior output word is taken.
module murmur2_hash_engine
  import mh2_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  mh2_in_if.sink   in_chan,
  mh2_out_if.source out_chan
);

  mul_req_t    mul_req;
  logic [31:0] product;
  fin_t        fin;
  logic        fin_ready;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r;

  mh2_mul u_mul (
    .clk     (clk),
    .req     (mul_req),
    .product (product)
  );

  mh2_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .mul_req   (mul_req),
    .product   (product),
    .fin       (fin),
    .fin_ready (fin_ready)
  );

  assign fin_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin.valid && fin_ready) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid && fin_ready) begin
      out_hash_r <= fin.hash;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.hash  = out_hash_r;

  // no new word while a result is being handed off
  a_busy_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    fin.valid |-> !in_chan.ready)
    else $error("input taken while result pending");

  // a finished hash reaches the output register next cycle
  a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (fin.valid && fin_ready) |=> (out_chan.valid && out_chan.hash == $past(fin.hash)))
    else $error("finished hash not registered");

  // a blocked result keeps its value until the output frees up
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fin.valid && !fin_ready) |=> (fin.valid && $stable(fin.hash)))
    else $error("pending hash changed");

endmodule

>>> tb/sv/tb_murmur2_hash_engine.sv
// ----------------------------------------------------------------------------
// tb_murmur2_hash_engine
// Self-checking bench for the MurmurHash2 engine: drives message words with
// random gaps, predicts each hash in-bench and checks every result word in
// order while the result side stalls at random; the last phase has no gaps or stalls.
// ----------------------------------------------------------------------------
module tb_murmur2_hash_engine;
  import mh2_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_WORDS  = 550;
  localparam int unsigned SETTLE_TICKS = 16;

  typedef struct {
    logic        first;
    logic [31:0] msg_length;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;
    logic        after_drain;  // hold until every hash is back
  } msg_word_t;

  logic clk;
  logic rst_n;

  mh2_in_if  in_chan ();
  mh2_out_if out_chan ();

  murmur2_hash_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  msg_word_t   word_pending[$];
  logic [31:0] hash_expect[$];

  // predictor state
  logic [31:0] hash_acc;
  logic        msg_open;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned staged_count;
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          drain_next;

  initial begin
    clk                = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.first      = 1'b0;
    in_chan.msg_length = '0;
    in_chan.data_word  = '0;
    in_chan.byte_count = '0;
    in_chan.last       = 1'b0;
    out_chan.ready     = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the running hash by one accepted word; queue the hash on last.
  function automatic void murmur_fold(input msg_word_t w);
    logic [31:0] h;
    logic [31:0] k;
    logic [31:0] f;
    logic [2:0]  n;
    n = (w.byte_count > 3'd4) ? 3'd4 : w.byte_count;
    if (w.first) hash_acc = w.msg_length;
    msg_open = 1'b1;
    h = hash_acc;
    if (n == 3'd4) begin
      k = w.data_word * MIX_MUL;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MUL;
      h = (h * MIX_MUL) ^ k;
    end else if (n != 3'd0) begin
      case (n[1:0])
        TAIL_ONE: begin
          h = h ^ {24'd0, w.data_word[7:0]};
        end
        TAIL_TWO: begin
          h = h ^ {16'd0, w.data_word[15:0]};
        end
        default: begin
          h = h ^ {8'd0, w.data_word[23:0]};
        end
      endcase
      h = h * MIX_MUL;
    end
    hash_acc = h;
    if (w.last) begin
      f = h ^ (h >> FIN_SHIFT_A);
      f = f * MIX_MUL;
      f = f ^ (f >> FIN_SHIFT_B);
      hash_expect.push_back(f);
      hash_acc = '0;
      msg_open = 1'b0;
    end
  endfunction

  task automatic push_word(input logic first, input logic [31:0] len,
                           input logic [31:0] data, input logic [2:0] cnt,
                           input logic last);
    msg_word_t w;
    w.first       = first;
    w.msg_length  = len;
    w.data_word   = data;
    w.byte_count  = cnt;
    w.last        = last;
    w.after_drain = drain_next;
    drain_next    = 1'b0;
    word_pending.push_back(w);
    staged_count++;
  endtask

  // One message; keep_open leaves it unfinished so the next first abandons it.
  task automatic push_message(input bit keep_open);
    int unsigned n_full;
    int unsigned tail;
    int unsigned i;
    bit          tail_word;
    logic [31:0] len;
    logic [2:0]  cnt;
    n_full = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
    tail   = $urandom_range(0, 3);
    len    = ($urandom_range(0, 7) == 0) ? $urandom : 4 * n_full + tail;
    tail_word = (tail != 0) || (n_full == 0) || ($urandom_range(0, 1) == 0);
    for (i = 0; i < n_full; i++) begin
      cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
      push_word(i == 0, len, $urandom, cnt,
                !tail_word && (i == n_full - 1) && !keep_open);
    end
    if (tail_word) push_word(n_full == 0, len, $urandom, 3'(tail), !keep_open);
  endtask

  task automatic push_random_phase(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    start = staged_count;
    while (staged_count - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) push_message(1'b0);
      else if (pick < 90) push_message(1'b1);
      else push_word(1'($urandom_range(0, 1)), $urandom, $urandom,
                     3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_words_sent();
    while (word_pending.size() != 0 || in_chan.valid) @(posedge clk);
  endtask

  // word source
  always @(posedge clk) begin : drive_words
    msg_word_t nxt;
    logic      fire;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      fire = in_chan.valid && in_chan.ready;
      if (fire) murmur_fold(word_pending.pop_front());
      if (in_chan.valid && !fire) begin
        // word still offered, hold it
      end else if (word_pending.size() != 0
                   && !(word_pending[0].after_drain && hash_expect.size() != 0)
                   && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = word_pending[0];
        in_chan.first      <= nxt.first;
        in_chan.msg_length <= nxt.msg_length;
        in_chan.data_word  <= nxt.data_word;
        in_chan.byte_count <= nxt.byte_count;
        in_chan.last       <= nxt.last;
        in_chan.valid      <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // hash sink and checker
  always @(posedge clk) begin : watch_hashes
    logic [31:0] want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (hash_expect.size() == 0) begin
          $display("%0t: hash word with none expected: expected none, actual %08h",
                   $time, out_chan.hash);
          fail_count++;
        end else begin
          want = hash_expect.pop_front();
          if (out_chan.hash !== want) begin
            $display("%0t: hash mismatch: expected %08h, actual %08h",
                     $time, want, out_chan.hash);
            fail_count++;
          end
        end
      end
      out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d hash words outstanding", $time, hash_expect.size());
      $display("murmur2_hash_engine test failed");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    hash_acc       = '0;
    msg_open       = 1'b0;
    send_idle_pct  = 34;
    recv_stall_pct = 53;
    staged_count   = 0;
    fail_count     = 0;
    cycle_count    = 0;
    drain_next     = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // words outside any message run against a zero hash
    push_word(1'b0, 32'hffff_ffff, 32'hffff_ffff, 3'd4, 1'b0);
    push_word(1'b0, 32'h0, 32'h1234_5678, 3'd0, 1'b1);
    // single-word messages, extremes of length and data
    push_word(1'b1, 32'h0, 32'h0, 3'd0, 1'b1);
    push_word(1'b1, 32'hffff_ffff, 32'hffff_ffff, 3'd4, 1'b1);
    push_word(1'b1, 32'h4, 32'h0, 3'd4, 1'b1);
    // tails of one to three bytes, junk above the count
    push_word(1'b1, 32'h3, 32'haabb_ccdd, 3'd3, 1'b1);
    push_word(1'b1, 32'h2, 32'haabb_ccdd, 3'd2, 1'b1);
    push_word(1'b1, 32'h1, 32'hffff_ff80, 3'd1, 1'b1);
    // counts above four act as a full word
    push_word(1'b1, 32'h8, 32'h8765_4321, 3'd7, 1'b0);
    push_word(1'b0, 32'h0, 32'h0f0f_f0f0, 3'd5, 1'b1);
    push_word(1'b1, 32'h4, 32'h7fff_ffff, 3'd6, 1'b1);
    // restart while a message is open
    push_word(1'b1, 32'h8, 32'hdead_beef, 3'd4, 1'b0);
    push_word(1'b1, 32'h4, 32'hcafe_f00d, 3'd4, 1'b1);
    // partial first word, a full word, then an empty closing word
    push_word(1'b1, 32'h6, 32'h5555_aaaa, 3'd2, 1'b0);
    push_word(1'b0, 32'h0, 32'h0102_0304, 3'd4, 1'b0);
    push_word(1'b0, 32'h0, 32'h0, 3'd0, 1'b1);

    push_random_phase(PHASE_WORDS);
    wait_words_sent();

    send_idle_pct  = 53;
    recv_stall_pct = 34;
    drain_next     = 1'b1;
    push_random_phase(PHASE_WORDS);
    wait_words_sent();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_next     = 1'b1;
    push_random_phase(PHASE_WORDS);
    wait_words_sent();

    while (hash_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    if (fail_count == 0 && hash_expect.size() == 0) begin
      $display("murmur2_hash_engine test passed");
    end else begin
      $display("murmur2_hash_engine test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/mh2_pkg.sv
rtl/core/mh2_if.sv
rtl/core/mh2_mul.sv
rtl/core/mh2_seq.sv
rtl/core/murmur2_hash_engine.sv
tb/sv/tb_murmur2_hash_engine.sv
